### rtl/edge_population_pair_checker_macros.svh
// assertion macros shared by the edge population pair checker rtl
`ifndef EDGE_POPULATION_PAIR_CHECKER_MACROS_SVH
`define EDGE_POPULATION_PAIR_CHECKER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define EPC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EPC_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define EPC_ASSERT(lbl, clk, rst_n, prop, msg)
`define EPC_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### rtl/epc_pkg.sv
// shared types and constants of the edge population pair checker
package epc_pkg;

    localparam int FIELD_W   = 32;
    localparam int CMD_W     = 2;
    localparam int ENTRIES   = 16;
    localparam int ENTRY_W   = 4;
    localparam int POP_W     = 4;
    localparam int POP_SLOTS = 16;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_RANGE_WR   = 2'd0,
        CMD_PERM_WR    = 2'd1,
        CMD_CHECK      = 2'd2,
        CMD_LIST_START = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_VALID         = 2'd0,
        ST_DEST_UNMAPPED = 2'd1,
        ST_SRC_UNMAPPED  = 2'd2,
        ST_FORBIDDEN     = 2'd3
    } t_status;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_OFFSET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_OFFSET   = 1'b1;

    typedef struct packed {
        logic               en;
        logic [ENTRY_W-1:0] index;
        logic [FIELD_W-1:0] first;
        logic [FIELD_W-1:0] size;
        logic [POP_W-1:0]   pop;
        logic               valid;
    } t_range_wr;

    typedef struct packed {
        logic             en;
        logic [POP_W-1:0] src;
        logic [POP_W-1:0] dst;
        logic             allowed;
    } t_perm_wr;

    typedef struct packed {
        logic             mapped;
        logic [POP_W-1:0] pop;
    } t_map_res;

endpackage

### rtl/epc_range_map.sv
// range table with pairwise start ordering and the two-stage id to population lookup
module epc_range_map #(
    parameter int ID_W = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  epc_pkg::t_range_wr i_wr,
    input  logic               i_en3,
    input  logic               i_en4,
    input  logic [ID_W-1:0]    i_src_id,
    input  logic [ID_W-1:0]    i_dst_id,
    output epc_pkg::t_map_res  o_src_map,
    output epc_pkg::t_map_res  o_dst_map
);
    import epc_pkg::*;

    logic [ID_W-1:0]    r_start [ENTRIES];
    logic [FIELD_W-1:0] r_count [ENTRIES];
    logic [POP_W-1:0]   r_pop   [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    // r_dom[k][j]: entry k beats entry j (higher start, lower index on a tie)
    logic [ENTRIES-1:0][ENTRIES-1:0] r_dom;

    logic [ID_W-1:0]    wr_start;
    logic [ENTRIES-1:0] wr_above;

    logic [ENTRIES-1:0] ge_src, ge_dst, inb_src, inb_dst;
    logic [ENTRIES-1:0] r_ge_src, r_ge_dst, r_inb_src, r_inb_dst;
    logic [ENTRIES-1:0] best_src, best_dst, top_entry;
    t_map_res           src_map, dst_map;
    t_map_res           r_src_map, r_dst_map;

    function automatic logic [ENTRIES-1:0] pick(
        input logic [ENTRIES-1:0]               cand,
        input logic [ENTRIES-1:0][ENTRIES-1:0] dom
    );
        logic [ENTRIES-1:0] sel;
        sel = cand;
        for (int k = 0; k < ENTRIES; k++) begin
            for (int j = 0; j < ENTRIES; j++) begin
                if (j != k && cand[j] && !dom[k][j]) begin
                    sel[k] = 1'b0;
                end
            end
        end
        return sel;
    endfunction

    // the bound only applies when the chosen entry is also the topmost one
    function automatic t_map_res resolve(
        input logic [ENTRIES-1:0] best,
        input logic [ENTRIES-1:0] inb,
        input logic [ENTRIES-1:0] top
    );
        t_map_res res;
        res.mapped = (|best) && ((best != top) || (|(best & inb)));
        res.pop    = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            if (best[k]) begin
                res.pop = res.pop | r_pop[k];
            end
        end
        if (!res.mapped) begin
            res.pop = '0;
        end
        return res;
    endfunction

    assign wr_start = i_wr.first[ID_W-1:0];

    always_comb begin
        for (int j = 0; j < ENTRIES; j++) begin
            wr_above[j] = (wr_start > r_start[j]) ||
                          ((wr_start == r_start[j]) && (i_wr.index < ENTRY_W'(j)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.index] <= i_wr.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_start[i_wr.index] <= wr_start;
            r_count[i_wr.index] <= i_wr.size;
            r_pop[i_wr.index]   <= i_wr.pop;
            for (int j = 0; j < ENTRIES; j++) begin
                if (ENTRY_W'(j) != i_wr.index) begin
                    r_dom[i_wr.index][ENTRY_W'(j)] <= wr_above[j];
                    r_dom[ENTRY_W'(j)][i_wr.index] <= !wr_above[j];
                end
            end
        end
    end

    // per entry: start not above id, and offset within the entry's count
    always_comb begin
        logic [ID_W-1:0] d_src;
        logic [ID_W-1:0] d_dst;
        d_src = '0;
        d_dst = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            d_src      = i_src_id - r_start[k];
            d_dst      = i_dst_id - r_start[k];
            ge_src[k]  = r_valid[k] && (r_start[k] <= i_src_id);
            ge_dst[k]  = r_valid[k] && (r_start[k] <= i_dst_id);
            inb_src[k] = FIELD_W'(d_src) <= r_count[k];
            inb_dst[k] = FIELD_W'(d_dst) <= r_count[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en3) begin
            r_ge_src  <= ge_src;
            r_ge_dst  <= ge_dst;
            r_inb_src <= inb_src;
            r_inb_dst <= inb_dst;
        end
    end

    always_comb begin
        best_src  = pick(r_ge_src, r_dom);
        best_dst  = pick(r_ge_dst, r_dom);
        top_entry = pick(r_valid, r_dom);
        src_map   = resolve(best_src, r_inb_src, top_entry);
        dst_map   = resolve(best_dst, r_inb_dst, top_entry);
    end

    always_ff @(posedge i_clk) begin
        if (i_en4) begin
            r_src_map <= src_map;
            r_dst_map <= dst_map;
        end
    end

    assign o_src_map = r_src_map;
    assign o_dst_map = r_dst_map;

endmodule

### rtl/epc_pair_perm.sv
// population pair permission matrix and edge status decision
module epc_pair_perm #(
    parameter int NUM_POPS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  epc_pkg::t_perm_wr i_wr,
    input  epc_pkg::t_map_res i_src_map,
    input  epc_pkg::t_map_res i_dst_map,
    output epc_pkg::t_status  o_status
);
    import epc_pkg::*;

    localparam int             PopLim  = (NUM_POPS < POP_SLOTS) ? NUM_POPS : POP_SLOTS;
    localparam logic [POP_W:0] PopLimV = (POP_W + 1)'(PopLim);

    logic [POP_SLOTS-1:0] r_rows [POP_SLOTS];

    function automatic logic pop_ok(input logic [POP_W-1:0] pop);
        return {1'b0, pop} < PopLimV;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < POP_SLOTS; r++) begin
                r_rows[r] <= '0;
            end
        end else if (i_wr.en && pop_ok(i_wr.src) && pop_ok(i_wr.dst)) begin
            r_rows[i_wr.src][i_wr.dst] <= i_wr.allowed;
        end
    end

    // destination is checked before source
    always_comb begin
        if (!i_dst_map.mapped) begin
            o_status = ST_DEST_UNMAPPED;
        end else if (!i_src_map.mapped) begin
            o_status = ST_SRC_UNMAPPED;
        end else if (pop_ok(i_src_map.pop) && pop_ok(i_dst_map.pop) &&
                     r_rows[i_src_map.pop][i_dst_map.pop]) begin
            o_status = ST_VALID;
        end else begin
            o_status = ST_FORBIDDEN;
        end
    end

endmodule

### rtl/edge_population_pair_checker.sv
// Edge population pair checker: one command word per cycle unless stalled (range write,
// permission write, edge check, list start); an edge check gives its result through register
// stages for offset add, per-entry range compare, best-entry select, and permission lookup
// into the output register. Checks stream back to back at one per cycle while results are
// not stalled. A range or permission write is held off while an edge check is still in the
// pipe, since the tables are read across three stages. Out of reset every range entry is
// invalid and every pair is forbidden, so no clearing pass is needed. The user must write
// offsets through the configuration port only while the block is idle; the block itself
// does not enforce this.
`include "edge_population_pair_checker_macros.svh"
module edge_population_pair_checker #(
    parameter int NUM_POPS  = 16,
    parameter int NODE_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [epc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [epc_pkg::FIELD_W-1:0]       i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [epc_pkg::CMD_W-1:0]         i_command,
    input  logic [epc_pkg::ENTRY_W-1:0]       i_entry_index,
    input  logic [epc_pkg::FIELD_W-1:0]       i_range_first,
    input  logic [epc_pkg::FIELD_W-1:0]       i_range_size,
    input  logic [epc_pkg::POP_W-1:0]         i_range_population,
    input  logic                              i_entry_valid,
    input  logic [epc_pkg::POP_W-1:0]         i_perm_source_pop,
    input  logic [epc_pkg::POP_W-1:0]         i_perm_dest_pop,
    input  logic                              i_perm_allowed,
    input  logic [epc_pkg::FIELD_W-1:0]       i_source_node,
    input  logic [epc_pkg::FIELD_W-1:0]       i_dest_node,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [epc_pkg::STATUS_W-1:0]      o_status,
    output logic [epc_pkg::POP_W-1:0]         o_source_pop,
    output logic [epc_pkg::POP_W-1:0]         o_dest_pop,
    output logic                              o_list_ok
);
    import epc_pkg::*;

    localparam int ID_W = (NODE_BITS < FIELD_W) ? NODE_BITS : FIELD_W;

    logic [FIELD_W-1:0] r_src_offset, r_dst_offset;

    // stage 1: registered command word
    logic               r_s1_valid;
    t_cmd               r_s1_cmd;
    logic [ENTRY_W-1:0] r_s1_entry_index;
    logic [FIELD_W-1:0] r_s1_range_first;
    logic [FIELD_W-1:0] r_s1_range_size;
    logic [POP_W-1:0]   r_s1_range_pop;
    logic               r_s1_entry_valid;
    logic [POP_W-1:0]   r_s1_perm_src;
    logic [POP_W-1:0]   r_s1_perm_dst;
    logic               r_s1_perm_allowed;
    logic [FIELD_W-1:0] r_s1_src_node;
    logic [FIELD_W-1:0] r_s1_dst_node;

    // stages 2..4 carry a check flag; a clear flag means list start
    logic               r_s2_valid, r_s2_chk;
    logic [ID_W-1:0]    r_s2_src_id, r_s2_dst_id;
    logic               r_s3_valid, r_s3_chk;
    logic               r_s4_valid, r_s4_chk;

    logic               r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [POP_W-1:0]   r_source_pop, r_dest_pop;
    logic               r_list_ok;
    logic               r_verdict;
    logic               n_verdict;

    logic out_free, leave4, en4, leave3, en3, leave2, en2, leave1, en1;
    logic s1_wr, busy, in_acc, late_chk;

    t_range_wr range_wr;
    t_perm_wr  perm_wr;
    t_map_res  src_map, dst_map;
    t_status   status;

    function automatic logic is_table_write(input t_cmd c);
        return (c == CMD_RANGE_WR) || (c == CMD_PERM_WR);
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_offset <= '0;
            r_dst_offset <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SOURCE_OFFSET: r_src_offset <= i_cfg_data;
                CFG_DEST_OFFSET:   r_dst_offset <= i_cfg_data;
            endcase
        end
    end

    // stall chain; a table write retires from stage 1 without going further
    always_comb begin
        out_free = !r_out_valid || i_ready;
        leave4   = r_s4_valid && out_free;
        en4      = !r_s4_valid || leave4;
        leave3   = r_s3_valid && en4;
        en3      = !r_s3_valid || leave3;
        leave2   = r_s2_valid && en3;
        en2      = !r_s2_valid || leave2;
        s1_wr    = is_table_write(r_s1_cmd);
        leave1   = r_s1_valid && (s1_wr || en2);
        en1      = !r_s1_valid || leave1;
        late_chk = (r_s2_valid && r_s2_chk) || (r_s3_valid && r_s3_chk) ||
                   (r_s4_valid && r_s4_chk);
        busy     = (r_s1_valid && (r_s1_cmd == CMD_CHECK)) || late_chk;
        o_ready  = en1 && !(is_table_write(t_cmd'(i_command)) && busy);
        in_acc   = i_valid && o_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en1) begin
                r_s1_valid <= in_acc;
            end
            if (en2) begin
                r_s2_valid <= r_s1_valid && !s1_wr;
            end
            if (en3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (en4) begin
                r_s4_valid <= r_s3_valid;
            end
            if (out_free) begin
                r_out_valid <= leave4 && r_s4_chk;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cmd          <= t_cmd'(i_command);
            r_s1_entry_index  <= i_entry_index;
            r_s1_range_first  <= i_range_first;
            r_s1_range_size   <= i_range_size;
            r_s1_range_pop    <= i_range_population;
            r_s1_entry_valid  <= i_entry_valid;
            r_s1_perm_src     <= i_perm_source_pop;
            r_s1_perm_dst     <= i_perm_dest_pop;
            r_s1_perm_allowed <= i_perm_allowed;
            r_s1_src_node     <= i_source_node;
            r_s1_dst_node     <= i_dest_node;
        end
        if (en2) begin
            r_s2_chk    <= r_s1_cmd == CMD_CHECK;
            r_s2_src_id <= r_s1_src_node[ID_W-1:0] + r_src_offset[ID_W-1:0];
            r_s2_dst_id <= r_s1_dst_node[ID_W-1:0] + r_dst_offset[ID_W-1:0];
        end
        if (en3) begin
            r_s3_chk <= r_s2_chk;
        end
        if (en4) begin
            r_s4_chk <= r_s3_chk;
        end
    end

    always_comb begin
        range_wr.en    = r_s1_valid && (r_s1_cmd == CMD_RANGE_WR);
        range_wr.index = r_s1_entry_index;
        range_wr.first = r_s1_range_first;
        range_wr.size  = r_s1_range_size;
        range_wr.pop   = r_s1_range_pop;
        range_wr.valid = r_s1_entry_valid;
        perm_wr.en      = r_s1_valid && (r_s1_cmd == CMD_PERM_WR);
        perm_wr.src     = r_s1_perm_src;
        perm_wr.dst     = r_s1_perm_dst;
        perm_wr.allowed = r_s1_perm_allowed;
    end

    epc_range_map #(
        .ID_W (ID_W)
    ) u_range_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (range_wr),
        .i_en3     (en3),
        .i_en4     (en4),
        .i_src_id  (r_s2_src_id),
        .i_dst_id  (r_s2_dst_id),
        .o_src_map (src_map),
        .o_dst_map (dst_map)
    );

    epc_pair_perm #(
        .NUM_POPS (NUM_POPS)
    ) u_pair_perm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (perm_wr),
        .i_src_map (src_map),
        .i_dst_map (dst_map),
        .o_status  (status)
    );

    // sticky flag, updated in order as words leave stage 4
    always_comb begin
        n_verdict = r_verdict;
        if (leave4) begin
            if (!r_s4_chk) begin
                n_verdict = 1'b1;
            end else if (status != ST_VALID) begin
                n_verdict = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_verdict <= 1'b1;
        end else begin
            r_verdict <= n_verdict;
        end
    end

    always_ff @(posedge i_clk) begin
        if (leave4 && r_s4_chk) begin
            r_status     <= status;
            r_source_pop <= src_map.pop;
            r_dest_pop   <= dst_map.pop;
            r_list_ok    <= n_verdict;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_source_pop = r_source_pop;
    assign o_dest_pop   = r_dest_pop;
    assign o_list_ok    = r_list_ok;

    `EPC_NEVER(a_wr_into_busy_pipe, i_clk, i_rst_n, (range_wr.en || perm_wr.en) && late_chk,
               "table write while a check is in flight")
    `EPC_ASSERT(a_list_start_sets_flag, i_clk, i_rst_n, leave4 && !r_s4_chk |=> r_verdict,
                "list start did not set the flag")
    `EPC_ASSERT(a_bad_status_clears_ok, i_clk, i_rst_n,
                o_valid && (o_status != ST_VALID) |-> !o_list_ok, "failed edge with list ok set")
    `EPC_ASSERT(a_out_from_check, i_clk, i_rst_n,
                $rose(r_out_valid) |-> $past(r_s4_valid && r_s4_chk), "result word without a check")

endmodule
